// File: rtl/tcw_pkg.sv
// Package for the text console writer: geometry constants, codes and
// the payload, command and status structs shared by the controller, datapath and top level.
// No dependencies.
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 8;
	localparam int CELLS     = ROWS * COLUMNS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int CELL_W    = 16;
	localparam int COL_W     = 7;
	localparam int ROW_W     = 5;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_RETURN  = 8'h0D;

	localparam logic REG_BACKGROUND = 1'b0;
	localparam logic REG_FOREGROUND = 1'b1;

	localparam logic [3:0] BACKGROUND_RESET = 4'd1;
	localparam logic [3:0] FOREGROUND_RESET = 4'd7;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  char_code;
		logic        last_char;
		logic [10:0] cell_index;
	} tcw_in_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] read_char;
		logic [7:0] read_attr;
		logic       scrolled;
		logic       call_done;
	} tcw_out_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic rd_issue;
		logic rd_capture;
		logic cnt_clear;
		logic cnt_inc;
		logic copy_step;
		logic zero_step;
		logic clear_home;
		logic load_out;
	} tcw_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       wrap;
		logic       idx_ok;
		logic       copy_end;
		logic       zero_end;
		logic       out_free;
	} tcw_sts_t;

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcw_ram #(
	parameter int DEPTH  = 2000,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/tcw_datapath.sv
// Datapath of the text console writer: cell buffer, cursor, color
// registers, sweep counter and output register. Uses tcw_pkg, tcw_ram.
`default_nettype none

module tcw_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tcw_pkg::tcw_in_t in_data,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [3:0]       cfg_data,
	input  wire tcw_pkg::tcw_cmd_t cmd,
	output tcw_pkg::tcw_sts_t     sts,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output tcw_pkg::tcw_out_t     out_data
);

	localparam int AW = tcw_pkg::ADDR_W;

	tcw_pkg::tcw_in_t  item_q;
	tcw_pkg::tcw_out_t out_q;
	logic              out_valid_q;
	logic [6:0]        col_q;
	logic [4:0]        row_q;
	logic [3:0]        bg_q;
	logic [3:0]        fg_q;
	logic [7:0]        rchar_q;
	logic [7:0]        rattr_q;
	logic              scrolled_q;
	logic [AW-1:0]     cnt_q;

	logic [7:0]        col_ext;
	logic [7:0]        col_inc;
	logic [7:0]        col_tab;
	logic [6:0]        ncol;
	logic [5:0]        nrow;
	logic              glyph;
	logic              wrap;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [15:0]       ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [15:0]       ram_rdata;

	// cursor update for a write item
	always_comb begin
		col_ext = {1'b0, col_q};
		col_inc = col_ext + 8'd1;
		col_tab = col_ext + 8'(tcw_pkg::TAB_WIDTH) - (col_ext % 8'(tcw_pkg::TAB_WIDTH));
		glyph   = 1'b0;
		ncol    = col_q;
		nrow    = {1'b0, row_q};
		case (item_q.char_code)
			tcw_pkg::CH_NEWLINE: begin
				ncol = 7'd0;
				nrow = {1'b0, row_q} + 6'd1;
			end
			tcw_pkg::CH_RETURN: begin
				ncol = 7'd0;
			end
			tcw_pkg::CH_TAB: begin
				if (col_tab >= 8'(tcw_pkg::COLUMNS)) begin
					ncol = 7'd0;
					nrow = {1'b0, row_q} + 6'd1;
				end else begin
					ncol = col_tab[6:0];
				end
			end
			default: begin
				glyph = 1'b1;
				if (col_inc >= 8'(tcw_pkg::COLUMNS)) begin
					ncol = 7'd0;
					nrow = {1'b0, row_q} + 6'd1;
				end else begin
					ncol = col_inc[6:0];
				end
			end
		endcase
		wrap = nrow >= 6'(tcw_pkg::ROWS);
	end

	// cell buffer port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = 16'd0;
		ram_re    = 1'b0;
		ram_raddr = item_q.cell_index[AW-1:0];
		if (cmd.exec && glyph) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(row_q) * AW'(tcw_pkg::COLUMNS) + AW'(col_q);
			ram_wdata = {bg_q, fg_q, item_q.char_code};
		end else if (cmd.copy_step) begin
			ram_we    = cnt_q != '0;
			ram_waddr = cnt_q - AW'(1);
			ram_wdata = ram_rdata;
			ram_re    = cnt_q < AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
			ram_raddr = cnt_q + AW'(tcw_pkg::COLUMNS);
		end else if (cmd.zero_step) begin
			ram_we    = 1'b1;
		end
		if (cmd.rd_issue) begin
			ram_re = 1'b1;
		end
	end

	tcw_ram #(
		.DEPTH (tcw_pkg::CELLS),
		.WIDTH (tcw_pkg::CELL_W),
		.ADDR_W(AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			bg_q        <= tcw_pkg::BACKGROUND_RESET;
			fg_q        <= tcw_pkg::FOREGROUND_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tcw_pkg::REG_BACKGROUND) begin
					bg_q <= cfg_data;
				end else begin
					fg_q <= cfg_data;
				end
			end
			if (cmd.exec) begin
				col_q <= ncol;
				row_q <= wrap ? 5'(tcw_pkg::ROWS - 1) : nrow[4:0];
			end
			if (cmd.clear_home) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q     <= in_data;
			rchar_q    <= '0;
			rattr_q    <= '0;
			scrolled_q <= 1'b0;
		end
		if (cmd.exec) begin
			scrolled_q <= wrap;
		end
		if (cmd.rd_capture) begin
			rchar_q <= ram_rdata[7:0];
			rattr_q <= ram_rdata[15:8];
		end
		if (cmd.load_out) begin
			out_q.cursor_col <= col_q;
			out_q.cursor_row <= row_q;
			out_q.read_char  <= rchar_q;
			out_q.read_attr  <= rattr_q;
			out_q.scrolled   <= scrolled_q;
			out_q.call_done  <= (item_q.op == tcw_pkg::OP_WRITE) && item_q.last_char;
		end
	end

	assign sts.op       = item_q.op;
	assign sts.wrap     = wrap;
	assign sts.idx_ok   = item_q.cell_index < 11'(tcw_pkg::CELLS);
	assign sts.copy_end = cnt_q == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
	assign sts.zero_end = cnt_q == AW'(tcw_pkg::CELLS - 1);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: rtl/tcw_ctrl.sv
// Controller of the text console writer: sequences the buffer clear at
// reset, item decode, reads, scroll and clear sweeps. Uses tcw_pkg.
`default_nettype none

module tcw_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire tcw_pkg::tcw_sts_t sts,
	output tcw_pkg::tcw_cmd_t cmd
);

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_ZERO   = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.zero_step = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.zero_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.op)
					tcw_pkg::OP_WRITE: begin
						cmd.exec = 1'b1;
						if (sts.wrap) begin
							cmd.cnt_clear = 1'b1;
							state_d       = ST_SCROLL;
						end else begin
							state_d = ST_FINISH;
						end
					end
					tcw_pkg::OP_CLEAR: begin
						cmd.clear_home = 1'b1;
						cmd.cnt_clear  = 1'b1;
						state_d        = ST_ZERO;
					end
					tcw_pkg::OP_READ: begin
						if (sts.idx_ok) begin
							cmd.rd_issue = 1'b1;
							state_d      = ST_RDWAIT;
						end else begin
							state_d = ST_FINISH;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_RDWAIT: begin
				cmd.rd_capture = 1'b1;
				state_d        = ST_FINISH;
			end
			ST_SCROLL: begin
				cmd.copy_step = 1'b1;
				if (sts.copy_end) begin
					state_d = ST_ZERO;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_ZERO: begin
				cmd.zero_step = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (sts.zero_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// Top level of the text console writer: controller plus datapath.
// Uses tcw_pkg, tcw_ctrl, tcw_datapath.
//
// Input beats (in_valid/in_stall, in_data) carry one op each: write a
// character, clear the 80x25 buffer, or read one cell. Every beat gives
// exactly one output beat (out_valid/out_stall, out_data) with the
// cursor after the op, the read cell, and the scrolled and call_done flags.
// cfg_we with cfg_index 0 or 1 writes the background or foreground color.
// A glyph, tab, newline or return updates the cursor and goes to the
// output register; a read of an in-range cell first reads the RAM; a
// scroll copies one cell per cycle, then zeroes the bottom row; a clear
// zeroes one cell per cycle. The single RAM port pair sets this pace.
// One op is in flight at a time; in_stall is low only when idle.
// After reset the whole buffer is zeroed with in_stall high.
// A stalled result holds in the output register; the next op may be
// accepted meanwhile and its result waits until the register frees.
`default_nettype none

module text_console_writer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire tcw_pkg::tcw_in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tcw_pkg::tcw_out_t  out_data,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [3:0]    cfg_data
);

	tcw_pkg::tcw_cmd_t cmd;
	tcw_pkg::tcw_sts_t sts;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	tcw_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
